// ----- rtl/sbht_pkg.sv -----
// ----------------------------------------------------------------------------
// sbht_pkg: shared constants of the slab base hash table
// Table geometry, key width and derived index widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbht_pkg;

  // Address and reference width
  localparam int ADDR_W        = 48;
  // Slab alignment: low address bits dropped to form the key
  localparam int ALIGN_BITS    = 16;
  // Number of slots in the table
  localparam int TABLE_ENTRIES = 1024;

  // Derived widths
  localparam int KEY_W      = ADDR_W - ALIGN_BITS;
  localparam int IDX_W      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam bit TABLE_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);

  // Home slot reduction: quotient estimate by reciprocal multiply
  localparam int QUOT_W = KEY_W - IDX_W + 1;
  localparam logic [KEY_W:0] RECIP =
    (KEY_W + 1)'((64'd1 << (KEY_W + IDX_W)) / 64'(TABLE_ENTRIES));

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/sbht_req_if.sv -----
// ----------------------------------------------------------------------------
// sbht_req_if: request channel of the slab base hash table
// Valid/ready channel carrying command, address and header reference.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sbht_req_if;

  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [sbht_pkg::ADDR_W-1:0]  address;
  logic [sbht_pkg::ADDR_W-1:0]  header_ref;

  modport source (output valid, output command, output address, output header_ref,
                  input ready);
  modport sink   (input valid, input command, input address, input header_ref,
                  output ready);

endinterface

`default_nettype wire

// ----- rtl/sbht_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sbht_rsp_if: response channel of the slab base hash table
// Valid/ready channel carrying the ok flag and the found reference.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sbht_rsp_if;

  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [sbht_pkg::ADDR_W-1:0]  found_ref;

  modport source (output valid, output ok, output found_ref, input ready);
  modport sink   (input valid, input ok, input found_ref, output ready);

endinterface

`default_nettype wire

// ----- rtl/slab_base_hash_table_core.sv -----
// ----------------------------------------------------------------------------
// slab_base_hash_table_core: linear probing table of slab base references
// Maps an aligned slab base to a header reference; insert and lookup.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request: command (insert / lookup), address and
//   header_ref. rsp_o returns exactly one response per request: ok and
//   found_ref (zero unless a lookup hit).
//   A request is taken only while the sequencer is idle; one request is in
//   work at a time. Each probe reads one slot of the key/ref memory, one
//   probe per cycle through its single read port.
//   After accept, a request passes the start step, the probe state (one
//   slot per probe) and the finish step, which loads the response; the
//   reciprocal multiply home slot reduction (reduce, fold and fix steps)
//   comes first when TABLE_ENTRIES is not a power of two. A key of zero
//   goes straight to the finish step; the sequencer is idle again as the
//   response loads. After reset a sweep clears all TABLE_ENTRIES key
//   memory slots (1024 at the default size); req_i.ready stays low meanwhile.
//   The response sits in an output register; a stalled receiver holds it,
//   and the next request may be accepted and worked on meanwhile, waiting
//   in its final step until the output register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slab_base_hash_table_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sbht_req_if.sink   req_i,
  sbht_rsp_if.source rsp_o
);

  import sbht_pkg::*;

  // Sequencer states
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_REDUCE = 3'd2;
  localparam logic [2:0] ST_START  = 3'd3;
  localparam logic [2:0] ST_PROBE  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;
  localparam logic [2:0] ST_FOLD   = 3'd6;
  localparam logic [2:0] ST_FIX    = 3'd7;

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
    next_slot = (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  // Control state
  logic [2:0]        state_q, state_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  logic              out_valid_q, out_valid_d;

  // Datapath registers
  logic              cmd_q, cmd_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [ADDR_W-1:0] ref_q, ref_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W:0]    rem_q, rem_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic              res_ok_q, res_ok_d;
  logic [ADDR_W-1:0] res_ref_q, res_ref_d;
  logic              out_ok_q, out_ok_d;
  logic [ADDR_W-1:0] out_ref_q, out_ref_d;

  // Memory ports
  logic [KEY_W-1:0]  key_mem [TABLE_ENTRIES];
  logic [ADDR_W-1:0] ref_mem [TABLE_ENTRIES];
  logic [IDX_W-1:0]  rd_addr;
  logic [KEY_W-1:0]  rd_key_q;
  logic [ADDR_W-1:0] rd_ref_q;
  logic              key_we;
  logic              ref_we;
  logic [IDX_W-1:0]  wr_addr;
  logic [KEY_W-1:0]  wr_key;

  // Shared probe / reduce unit signals
  logic [KEY_W-1:0]   key_in;
  logic               slot_empty;
  logic               slot_match;
  logic [2*KEY_W:0]   rcp_prod;
  logic [KEY_W-1:0]   fold_diff;
  logic [IDX_W:0]     rem_fix;
  logic               out_free;

  assign key_in     = req_i.address[ADDR_W-1:ALIGN_BITS];
  assign slot_empty = (rd_key_q == '0);
  assign slot_match = (rd_key_q == key_q);
  // quotient estimate is exact or one short; the fix step corrects it
  assign rcp_prod   = {{(KEY_W + 1){1'b0}}, key_q} * {{KEY_W{1'b0}}, RECIP};
  assign fold_diff  = key_q - KEY_W'(quot_q) * KEY_W'(TABLE_ENTRIES);
  assign rem_fix    = (rem_q >= (IDX_W + 1)'(TABLE_ENTRIES))
                    ? rem_q - (IDX_W + 1)'(TABLE_ENTRIES) : rem_q;
  assign out_free   = !out_valid_q || rsp_o.ready;

  assign req_i.ready     = (state_q == ST_IDLE);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.ok        = out_ok_q;
  assign rsp_o.found_ref = out_ref_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    ref_d       = ref_q;
    slot_d      = slot_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    quot_d      = quot_q;
    res_ok_d    = res_ok_q;
    res_ref_d   = res_ref_q;
    out_ok_d    = out_ok_q;
    out_ref_d   = out_ref_q;
    rd_addr     = slot_q;
    key_we      = 1'b0;
    ref_we      = 1'b0;
    wr_addr     = slot_q;
    wr_key      = key_q;

    // drop the response once taken
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        key_we  = 1'b1;
        wr_addr = clr_q;
        wr_key  = '0;
        clr_d   = next_slot(clr_q);
        if (clr_q == LAST_SLOT) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          cmd_d     = req_i.command;
          key_d     = key_in;
          ref_d     = req_i.header_ref;
          cnt_d     = '0;
          res_ok_d  = 1'b0;
          res_ref_d = '0;
          rem_d     = '0;
          slot_d    = key_in[IDX_W-1:0];
          if (key_in == '0) begin
            state_d = ST_FINISH;
          end else if (TABLE_POW2) begin
            state_d = ST_START;
          end else begin
            state_d = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        // estimate the quotient by the table size
        quot_d  = rcp_prod[2*KEY_W:KEY_W+IDX_W];
        state_d = ST_FOLD;
      end
      ST_FOLD: begin
        // remainder, at most one table size too large
        rem_d   = fold_diff[IDX_W:0];
        state_d = ST_FIX;
      end
      ST_FIX: begin
        slot_d  = rem_fix[IDX_W-1:0];
        state_d = ST_START;
      end
      ST_START: begin
        rd_addr = slot_q;
        state_d = ST_PROBE;
      end
      ST_PROBE: begin
        // compare slot_q, read the following slot ahead
        rd_addr = next_slot(slot_q);
        if (cmd_q == CMD_INSERT && (slot_empty || slot_match)) begin
          key_we   = 1'b1;
          ref_we   = 1'b1;
          res_ok_d = 1'b1;
          state_d  = ST_FINISH;
        end else if (cmd_q == CMD_LOOKUP && slot_empty) begin
          state_d = ST_FINISH;
        end else if (cmd_q == CMD_LOOKUP && slot_match) begin
          res_ok_d  = 1'b1;
          res_ref_d = rd_ref_q;
          state_d   = ST_FINISH;
        end else if (cnt_q == LAST_SLOT) begin
          state_d = ST_FINISH;
        end else begin
          slot_d = next_slot(slot_q);
          cnt_d  = cnt_q + 1'b1;
        end
      end
      ST_FINISH: begin
        // hold until the output register frees
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ok_d    = res_ok_q;
          out_ref_d   = res_ref_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    key_q     <= key_d;
    ref_q     <= ref_d;
    slot_q    <= slot_d;
    cnt_q     <= cnt_d;
    rem_q     <= rem_d;
    quot_q    <= quot_d;
    res_ok_q  <= res_ok_d;
    res_ref_q <= res_ref_d;
    out_ok_q  <= out_ok_d;
    out_ref_q <= out_ref_d;
  end

  // Key memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    rd_key_q <= key_mem[rd_addr];
  end

  // Reference memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (ref_we) begin
      ref_mem[wr_addr] <= ref_q;
    end
    rd_ref_q <= ref_mem[rd_addr];
  end

  // Never store the empty mark from a request
  a_no_zero_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE && key_we) |-> (wr_key != '0))
    else $error("empty key written by insert");

  // Once the output register is free, a finished request lands in it next cycle
  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished request not loaded");

  // A response without ok never carries a reference: a miss or a failed insert
  a_miss_zero_ref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ok_q) |-> (out_ref_q == '0))
    else $error("miss with nonzero reference");

endmodule

`default_nettype wire
